### hw/rtl/rotor_cipher_engine_top_macros.svh
// Assertion macros for the rotor cipher engine.
// Included by rotor_cipher_engine_top; no other dependencies.
`ifndef ROTOR_CIPHER_ENGINE_TOP_MACROS_SVH
`define ROTOR_CIPHER_ENGINE_TOP_MACROS_SVH

// Same-cycle implication, held off during reset.
`define RCE_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, held off during reset.
`define RCE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hw/rtl/rce_pkg.sv
// Shared types and constants of the rotor cipher engine.
// No dependencies; used by rotor_cipher_engine_top.
package rce_pkg;

	localparam int MAX_SYMBOLS_DEF = 64;
	localparam int MAX_ROTORS_DEF  = 8;

	// width of index sums and alphabet compares (covers 256 symbols)
	localparam int SUM_W     = 9;
	// rotor loop counter, counts up to 16
	localparam int ROT_CNT_W = 5;

	localparam logic [6:0] ALPHA_RESET  = 7'd26;
	localparam logic [3:0] ROTORS_RESET = 4'd3;

	// register indexes on the configuration port
	localparam logic REG_ALPHABET_SIZE = 1'b0;
	localparam logic REG_ROTOR_COUNT   = 1'b1;

	// result status codes
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_NOKEY   = 2'd1;
	localparam logic [1:0] ST_RANGE   = 2'd2;
	localparam logic [1:0] ST_MISSING = 2'd3;

	typedef enum logic [2:0] {
		FN_ENCRYPT   = 3'd0,
		FN_LOAD_KBD  = 3'd1,
		FN_LOAD_ROT  = 3'd2,
		FN_LOAD_REFL = 3'd3,
		FN_SET_POS   = 3'd4,
		FN_RESET_POS = 3'd5
	} func_t;

endpackage

### hw/rtl/rce_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies; instanced for every table of the rotor cipher engine.
module rce_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### hw/rtl/rotor_cipher_engine_top.sv
// Rotor cipher engine. A command is taken when start is high and busy is low; its single
// result shows on out_symbol/status for exactly one cycle with done, and the receiver
// cannot stall it. For table loads, position set/reset and unused codes the result
// follows on the next cycle and busy stays low. An encrypt walks a sequencer around one
// shared add/compare-subtract unit and the table RAMs (one read per cycle, registered):
// a keyboard search slot by slot, then in each of the two passes, per rotor stage, an add,
// one subtract when the sum wraps past n (several when a position is left over from a
// larger alphabet) and a table lookup, with the reflector lookup between the passes, then
// the output lookup and the odometer step, busy high throughout. After reset a clearing
// pass over every address of the wiring tables (at least two rotor rows) wipes them with
// busy high; configuration writes are taken during it.
// Depends on rce_pkg, rce_ram and rotor_cipher_engine_top_macros.svh.
`include "rotor_cipher_engine_top_macros.svh"

module rotor_cipher_engine_top #(
	parameter int MAX_SYMBOLS = rce_pkg::MAX_SYMBOLS_DEF,
	parameter int MAX_ROTORS  = rce_pkg::MAX_ROTORS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// command
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  func,
	input  logic [7:0]  symbol,
	input  logic [2:0]  rotor_sel,
	input  logic [5:0]  index_a,
	input  logic [5:0]  index_b,
	// result
	output logic        done,
	output logic [7:0]  out_symbol,
	output logic [1:0]  status
);

	localparam int IDXW   = $clog2(MAX_SYMBOLS);
	localparam int RW     = (MAX_ROTORS > 1) ? $clog2(MAX_ROTORS) : 1;
	localparam int WAW    = RW + IDXW;
	localparam int WDEPTH = 1 << WAW;
	localparam int TW     = IDXW + 1;          // valid bit + index
	localparam int SW     = rce_pkg::SUM_W;
	localparam int CW     = rce_pkg::ROT_CNT_W;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_SEARCH,
		S_ADD,
		S_MOD,
		S_LOOK,
		S_REFL,
		S_REFL_LOOK,
		S_OUT,
		S_OUT_LOOK,
		S_STEP
	} state_t;

	// configuration
	logic [6:0]     alpha_q;
	logic [3:0]     rcount_q;
	logic [SW-1:0]  n_eff;
	logic [CW-1:0]  nr_eff;

	// sequencer
	state_t          state_q;
	logic            pass_rev_q;
	logic [WAW-1:0]  clr_q;
	logic [7:0]      sym_q;
	logic [IDXW-1:0] idx_q;
	logic [SW-1:0]   sum_q;
	logic [CW-1:0]   rot_q;
	logic [SW-1:0]   scan_q;
	logic            pend_q;
	logic [IDXW-1:0] pend_slot_q;
	logic [7:0]      osym_q;
	logic [IDXW-1:0] pos_q [MAX_ROTORS];

	logic            done_q;
	logic [7:0]      out_symbol_q;
	logic [1:0]      status_q;

	// tables
	logic            kbd_we;
	logic [IDXW-1:0] kbd_waddr, kbd_raddr;
	logic [7:0]      kbd_rdata;
	logic            fwd_we, rev_we, refl_we;
	logic [WAW-1:0]  fwd_waddr, rev_waddr, tab_raddr;
	logic [TW-1:0]   fwd_wdata, rev_wdata, fwd_rdata, rev_rdata;
	logic [IDXW-1:0] refl_waddr;
	logic [TW-1:0]   refl_wdata, refl_rdata;

	// helpers
	logic            accept, cfg_we, clearing;
	logic            a_ok, b_ok, r_ok, pos_ok;
	logic [IDXW-1:0] pos_cur;
	logic [SW-1:0]   pos_inc;
	logic [TW-1:0]   look_word;
	logic            match;

	assign pready   = 1'b1;
	assign cfg_we   = psel && penable && pwrite;
	assign busy     = (state_q != S_IDLE);
	assign accept   = start && !busy;
	assign clearing = (state_q == S_CLEAR);

	assign done       = done_q;
	assign out_symbol = out_symbol_q;
	assign status     = status_q;

	assign n_eff  = (SW'(alpha_q) > SW'(MAX_SYMBOLS)) ? SW'(MAX_SYMBOLS) : SW'(alpha_q);
	assign nr_eff = (CW'(rcount_q) > CW'(MAX_ROTORS)) ? CW'(MAX_ROTORS) : CW'(rcount_q);

	assign a_ok   = SW'(index_a) < SW'(MAX_SYMBOLS);
	assign b_ok   = SW'(index_b) < SW'(MAX_SYMBOLS);
	assign r_ok   = CW'(rotor_sel) < CW'(MAX_ROTORS);
	assign pos_ok = r_ok && (CW'(rotor_sel) < nr_eff) && (SW'(index_a) < n_eff);

	assign pos_cur   = pos_q[rot_q[RW-1:0]];
	assign pos_inc   = SW'(pos_cur) + SW'(1'b1);
	assign look_word = pass_rev_q ? rev_rdata : fwd_rdata;
	assign match     = pend_q && (kbd_rdata == sym_q);

	always_comb begin
		prdata = 32'd0;
		case (paddr[2])
			rce_pkg::REG_ALPHABET_SIZE: prdata = {25'd0, alpha_q};
			rce_pkg::REG_ROTOR_COUNT:   prdata = {28'd0, rcount_q};
			default:                    prdata = 32'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_q  <= rce_pkg::ALPHA_RESET;
			rcount_q <= rce_pkg::ROTORS_RESET;
		end else if (cfg_we) begin
			case (paddr[2])
				rce_pkg::REG_ALPHABET_SIZE: alpha_q  <= pwdata[6:0];
				rce_pkg::REG_ROTOR_COUNT:   rcount_q <= pwdata[3:0];
				default:                    alpha_q  <= alpha_q;
			endcase
		end
	end

	// table write and read ports
	always_comb begin
		kbd_we     = 1'b0;
		kbd_waddr  = IDXW'(index_a);
		fwd_we     = 1'b0;
		rev_we     = 1'b0;
		refl_we    = 1'b0;
		fwd_waddr  = {RW'(rotor_sel), IDXW'(index_a)};
		rev_waddr  = {RW'(rotor_sel), IDXW'(index_b)};
		fwd_wdata  = {1'b1, IDXW'(index_b)};
		rev_wdata  = {1'b1, IDXW'(index_a)};
		refl_waddr = IDXW'(index_a);
		refl_wdata = {1'b1, IDXW'(index_b)};
		if (clearing) begin
			fwd_we     = 1'b1;
			rev_we     = 1'b1;
			refl_we    = 1'b1;
			fwd_waddr  = clr_q;
			rev_waddr  = clr_q;
			refl_waddr = clr_q[IDXW-1:0];
			fwd_wdata  = '0;
			rev_wdata  = '0;
			refl_wdata = '0;
		end else if (accept) begin
			case (func)
				rce_pkg::FN_LOAD_KBD:  kbd_we = a_ok;
				rce_pkg::FN_LOAD_ROT: begin
					fwd_we = r_ok && a_ok && b_ok;
					rev_we = r_ok && a_ok && b_ok;
				end
				rce_pkg::FN_LOAD_REFL: refl_we = a_ok && b_ok;
				default:               kbd_we = 1'b0;
			endcase
		end
	end

	assign kbd_raddr = (state_q == S_SEARCH) ? scan_q[IDXW-1:0] : idx_q;
	assign tab_raddr = {rot_q[RW-1:0], sum_q[IDXW-1:0]};

	rce_ram #(.WIDTH(8), .DEPTH(MAX_SYMBOLS)) u_kbd_ram (
		.clk   (clk),
		.we    (kbd_we),
		.waddr (kbd_waddr),
		.wdata (symbol),
		.raddr (kbd_raddr),
		.rdata (kbd_rdata)
	);

	rce_ram #(.WIDTH(TW), .DEPTH(WDEPTH)) u_fwd_ram (
		.clk   (clk),
		.we    (fwd_we),
		.waddr (fwd_waddr),
		.wdata (fwd_wdata),
		.raddr (tab_raddr),
		.rdata (fwd_rdata)
	);

	rce_ram #(.WIDTH(TW), .DEPTH(WDEPTH)) u_rev_ram (
		.clk   (clk),
		.we    (rev_we),
		.waddr (rev_waddr),
		.wdata (rev_wdata),
		.raddr (tab_raddr),
		.rdata (rev_rdata)
	);

	rce_ram #(.WIDTH(TW), .DEPTH(1 << IDXW)) u_refl_ram (
		.clk   (clk),
		.we    (refl_we),
		.waddr (refl_waddr),
		.wdata (refl_wdata),
		.raddr (idx_q),
		.rdata (refl_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLEAR;
			clr_q        <= '0;
			pass_rev_q   <= 1'b0;
			sym_q        <= '0;
			idx_q        <= '0;
			sum_q        <= '0;
			rot_q        <= '0;
			scan_q       <= '0;
			pend_q       <= 1'b0;
			pend_slot_q  <= '0;
			osym_q       <= '0;
			done_q       <= 1'b0;
			out_symbol_q <= '0;
			status_q     <= rce_pkg::ST_OK;
			for (int i = 0; i < MAX_ROTORS; i++) begin
				pos_q[i] <= '0;
			end
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + WAW'(1);
					if (clr_q == '1) begin
						state_q <= S_IDLE;
					end
				end

				S_IDLE: begin
					if (accept) begin
						if (func == rce_pkg::FN_ENCRYPT) begin
							sym_q   <= symbol;
							scan_q  <= '0;
							pend_q  <= 1'b0;
							state_q <= S_SEARCH;
						end else begin
							done_q       <= 1'b1;
							out_symbol_q <= 8'd0;
							status_q     <= rce_pkg::ST_OK;
							case (func)
								rce_pkg::FN_LOAD_KBD: begin
									if (!a_ok) status_q <= rce_pkg::ST_RANGE;
								end
								rce_pkg::FN_LOAD_ROT: begin
									if (!(r_ok && a_ok && b_ok)) status_q <= rce_pkg::ST_RANGE;
								end
								rce_pkg::FN_LOAD_REFL: begin
									if (!(a_ok && b_ok)) status_q <= rce_pkg::ST_RANGE;
								end
								rce_pkg::FN_SET_POS: begin
									if (pos_ok) begin
										pos_q[RW'(rotor_sel)] <= IDXW'(index_a);
									end else begin
										status_q <= rce_pkg::ST_RANGE;
									end
								end
								rce_pkg::FN_RESET_POS: begin
									for (int i = 0; i < MAX_ROTORS; i++) begin
										pos_q[i] <= '0;
									end
								end
								default: status_q <= rce_pkg::ST_RANGE;
							endcase
						end
					end
				end

				// keyboard data arrives in the cycle after its slot address
				S_SEARCH: begin
					if (match) begin
						idx_q      <= pend_slot_q;
						rot_q      <= '0;
						pass_rev_q <= 1'b0;
						state_q    <= (nr_eff == '0) ? S_REFL : S_ADD;
					end else if (!pend_q && (scan_q >= n_eff)) begin
						done_q       <= 1'b1;
						out_symbol_q <= 8'd0;
						status_q     <= rce_pkg::ST_NOKEY;
						state_q      <= S_IDLE;
					end else if (scan_q < n_eff) begin
						pend_q      <= 1'b1;
						pend_slot_q <= scan_q[IDXW-1:0];
						scan_q      <= scan_q + SW'(1);
					end else begin
						pend_q <= 1'b0;
					end
				end

				S_ADD: begin
					if (SW'(idx_q) >= n_eff) begin
						done_q       <= 1'b1;
						out_symbol_q <= 8'd0;
						status_q     <= rce_pkg::ST_RANGE;
						state_q      <= S_IDLE;
					end else begin
						sum_q   <= SW'(idx_q) + SW'(pos_cur);
						state_q <= S_MOD;
					end
				end

				// stale positions may need several subtracts
				S_MOD: begin
					if (sum_q >= n_eff) begin
						sum_q <= sum_q - n_eff;
					end else begin
						state_q <= S_LOOK;
					end
				end

				S_LOOK: begin
					if (!look_word[IDXW]) begin
						done_q       <= 1'b1;
						out_symbol_q <= 8'd0;
						status_q     <= rce_pkg::ST_MISSING;
						state_q      <= S_IDLE;
					end else begin
						idx_q <= look_word[IDXW-1:0];
						if (rot_q + CW'(1) == nr_eff) begin
							rot_q   <= '0;
							state_q <= pass_rev_q ? S_OUT : S_REFL;
						end else begin
							rot_q   <= rot_q + CW'(1);
							state_q <= S_ADD;
						end
					end
				end

				S_REFL: begin
					if (SW'(idx_q) >= SW'(MAX_SYMBOLS)) begin
						done_q       <= 1'b1;
						out_symbol_q <= 8'd0;
						status_q     <= rce_pkg::ST_MISSING;
						state_q      <= S_IDLE;
					end else begin
						state_q <= S_REFL_LOOK;
					end
				end

				S_REFL_LOOK: begin
					if (!refl_rdata[IDXW]) begin
						done_q       <= 1'b1;
						out_symbol_q <= 8'd0;
						status_q     <= rce_pkg::ST_MISSING;
						state_q      <= S_IDLE;
					end else begin
						idx_q      <= refl_rdata[IDXW-1:0];
						pass_rev_q <= 1'b1;
						rot_q      <= '0;
						state_q    <= (nr_eff == '0) ? S_OUT : S_ADD;
					end
				end

				S_OUT: begin
					if (SW'(idx_q) >= n_eff) begin
						done_q       <= 1'b1;
						out_symbol_q <= 8'd0;
						status_q     <= rce_pkg::ST_RANGE;
						state_q      <= S_IDLE;
					end else begin
						state_q <= S_OUT_LOOK;
					end
				end

				S_OUT_LOOK: begin
					osym_q  <= kbd_rdata;
					rot_q   <= '0;
					state_q <= S_STEP;
				end

				// odometer: advance rotor 0, carry on wrap
				S_STEP: begin
					if (rot_q >= nr_eff) begin
						done_q       <= 1'b1;
						out_symbol_q <= osym_q;
						status_q     <= rce_pkg::ST_OK;
						state_q      <= S_IDLE;
					end else if (pos_inc < n_eff) begin
						pos_q[rot_q[RW-1:0]] <= pos_inc[IDXW-1:0];
						done_q               <= 1'b1;
						out_symbol_q         <= osym_q;
						status_q             <= rce_pkg::ST_OK;
						state_q              <= S_IDLE;
					end else begin
						pos_q[rot_q[RW-1:0]] <= '0;
						rot_q                <= rot_q + CW'(1);
					end
				end

				default: state_q <= S_IDLE;
			endcase
		end
	end

	`RCE_ASSERT_IMPLY(a_err_no_symbol, clk, arst_n, done && (status != rce_pkg::ST_OK), out_symbol == 8'd0, "failed item carries a symbol")
	`RCE_ASSERT_IMPLY(a_enc_ends_done, clk, arst_n, (busy && !clearing) ##1 !busy, done, "encrypt ended without a result")
	`RCE_ASSERT_NEXT(a_cmd_one_cycle, clk, arst_n, accept && (func != rce_pkg::FN_ENCRYPT), done && !busy, "table command result missing")

endmodule

### tb/sv/rce_cipher_checker.sv
// Checker for rotor_cipher_engine_top: follows register writes and accepted commands,
// predicts each command's result and compares it with what comes out with done.
// Depends on rce_pkg; instantiated by tb_rotor_cipher_engine_top beside the engine.
module rce_cipher_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic        pready,
	input  logic        start,
	input  logic        busy,
	input  logic [2:0]  func,
	input  logic [7:0]  symbol,
	input  logic [2:0]  rotor_sel,
	input  logic [5:0]  index_a,
	input  logic [5:0]  index_b,
	input  logic        done,
	input  logic [7:0]  out_symbol,
	input  logic [1:0]  status,
	output int          mismatches,
	output int          outstanding
);
	import rce_pkg::*;

	localparam int NSYM = MAX_SYMBOLS_DEF;
	localparam int NROT = MAX_ROTORS_DEF;

	typedef struct packed {
		logic [7:0] ciphertext;
		logic [1:0] code;
	} reply_t;

	logic [6:0] alpha_reg;
	logic [3:0] rotors_reg;
	logic [7:0] kbd_char [NSYM];
	logic [5:0] fwd_dst [NROT][NSYM];
	bit         fwd_set [NROT][NSYM];
	logic [5:0] rev_src [NROT][NSYM];
	bit         rev_set [NROT][NSYM];
	logic [5:0] refl_dst [NSYM];
	bit         refl_set [NSYM];
	logic [5:0] rotor_pos [NROT];
	reply_t     replies_due [$];
	int         fail_cnt = 0;

	function automatic int live_symbols();
		return (alpha_reg > NSYM) ? NSYM : int'(alpha_reg);
	endfunction

	function automatic int live_rotors();
		return (rotors_reg > NROT) ? NROT : int'(rotors_reg);
	endfunction

	function automatic logic [1:0] encipher(input logic [7:0] plain, output logic [7:0] cipher);
		int n;
		int nr;
		int idx;
		int r;
		bit hit;
		bit carry;
		n = live_symbols();
		nr = live_rotors();
		idx = 0;
		hit = 1'b0;
		cipher = '0;
		// lowest matching slot wins
		for (r = 0; r < n; r++) begin
			if (!hit && kbd_char[r] == plain) begin
				idx = r;
				hit = 1'b1;
			end
		end
		if (!hit)
			return ST_NOKEY;
		for (r = 0; r < nr; r++) begin
			if (idx >= n)
				return ST_RANGE;
			idx = (idx + rotor_pos[r]) % n;
			if (!fwd_set[r][idx])
				return ST_MISSING;
			idx = fwd_dst[r][idx];
		end
		if (!refl_set[idx])
			return ST_MISSING;
		idx = refl_dst[idx];
		// return pass walks the rotors in the same order
		for (r = 0; r < nr; r++) begin
			if (idx >= n)
				return ST_RANGE;
			idx = (idx + rotor_pos[r]) % n;
			if (!rev_set[r][idx])
				return ST_MISSING;
			idx = rev_src[r][idx];
		end
		if (idx >= n)
			return ST_RANGE;
		cipher = kbd_char[idx];
		// odometer; a stale position past n wraps to zero and carries
		carry = 1'b1;
		for (r = 0; r < nr; r++) begin
			if (carry) begin
				if (rotor_pos[r] + 1 < n) begin
					rotor_pos[r] = 6'(rotor_pos[r] + 1);
					carry = 1'b0;
				end else begin
					rotor_pos[r] = '0;
				end
			end
		end
		return ST_OK;
	endfunction

	function automatic reply_t apply_command(input logic [2:0] fn, input logic [7:0] sym,
			input logic [2:0] rsel, input logic [5:0] a, input logic [5:0] b);
		reply_t rep;
		logic [7:0] ct;
		int r;
		rep.ciphertext = '0;
		rep.code = ST_OK;
		case (fn)
			FN_ENCRYPT: begin
				rep.code = encipher(sym, ct);
				if (rep.code == ST_OK)
					rep.ciphertext = ct;
			end
			FN_LOAD_KBD: begin
				kbd_char[a] = sym;
			end
			FN_LOAD_ROT: begin
				if (rsel >= NROT) begin
					rep.code = ST_RANGE;
				end else begin
					fwd_dst[rsel][a] = b;
					fwd_set[rsel][a] = 1'b1;
					rev_src[rsel][b] = a;
					rev_set[rsel][b] = 1'b1;
				end
			end
			FN_LOAD_REFL: begin
				refl_dst[a] = b;
				refl_set[a] = 1'b1;
			end
			FN_SET_POS: begin
				if (rsel >= live_rotors() || a >= live_symbols())
					rep.code = ST_RANGE;
				else
					rotor_pos[rsel] = a;
			end
			FN_RESET_POS: begin
				for (r = 0; r < NROT; r++)
					rotor_pos[r] = '0;
			end
			default: begin
				rep.code = ST_RANGE;
			end
		endcase
		return rep;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		reply_t want;
		int r;
		int i;
		if (!arst_n) begin
			alpha_reg = ALPHA_RESET;
			rotors_reg = ROTORS_RESET;
			for (i = 0; i < NSYM; i++) begin
				kbd_char[i] = '0;
				refl_set[i] = 1'b0;
				for (r = 0; r < NROT; r++) begin
					fwd_set[r][i] = 1'b0;
					rev_set[r][i] = 1'b0;
				end
			end
			for (r = 0; r < NROT; r++)
				rotor_pos[r] = '0;
			replies_due.delete();
			outstanding <= 0;
			mismatches <= fail_cnt;
		end else begin
			if (done) begin
				if (replies_due.size() == 0) begin
					$error("result with no command waiting: out_symbol %0h status %0d",
						out_symbol, status);
					fail_cnt++;
				end else begin
					want = replies_due.pop_front();
					if (out_symbol !== want.ciphertext) begin
						$error("out_symbol: expected %0h, got %0h", want.ciphertext, out_symbol);
						fail_cnt++;
					end
					if (status !== want.code) begin
						$error("status: expected %0d, got %0d", want.code, status);
						fail_cnt++;
					end
				end
			end
			if (start && !busy)
				replies_due.push_back(apply_command(func, symbol, rotor_sel, index_a, index_b));
			// register index sits above the byte offset
			if (psel && penable && pwrite && pready) begin
				if (paddr[2] == REG_ALPHABET_SIZE)
					alpha_reg = pwdata[6:0];
				else
					rotors_reg = pwdata[3:0];
			end
			outstanding <= replies_due.size();
			mismatches <= fail_cnt;
		end
	end

endmodule

### tb/sv/tb_rotor_cipher_engine_top.sv
// Testbench top for rotor_cipher_engine_top: loads cipher tables, sweeps register
// settings and sends directed then random commands; rce_cipher_checker does the checking.
// Depends on rce_pkg, rce_cipher_checker and the engine RTL.
module tb_rotor_cipher_engine_top;
	import rce_pkg::*;

	localparam logic [2:0] FN_SPARE_LO = 3'd6;
	localparam logic [2:0] FN_SPARE_HI = 3'd7;
	localparam int CYCLE_LIMIT = 10_000_000;
	localparam int NSYM = MAX_SYMBOLS_DEF;
	localparam int NROT = MAX_ROTORS_DEF;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        start = 1'b0;
	logic        busy;
	logic [2:0]  func = '0;
	logic [7:0]  symbol = '0;
	logic [2:0]  rotor_sel = '0;
	logic [5:0]  index_a = '0;
	logic [5:0]  index_b = '0;
	logic        done;
	logic [7:0]  out_symbol;
	logic [1:0]  status;
	int          mismatches;
	int          outstanding;

	int         cycle_cnt = 0;
	int         burst_left = 0;
	int         alpha_now = ALPHA_RESET;
	int         rotors_now = ROTORS_RESET;
	bit         kbd_set [NSYM];
	logic [7:0] kbd_copy [NSYM];
	int         perm_buf [NSYM];

	rotor_cipher_engine_top uut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
		.prdata(prdata), .pready(pready),
		.start(start), .busy(busy), .func(func), .symbol(symbol), .rotor_sel(rotor_sel),
		.index_a(index_a), .index_b(index_b),
		.done(done), .out_symbol(out_symbol), .status(status)
	);

	rce_cipher_checker watch (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
		.pready(pready),
		.start(start), .busy(busy), .func(func), .symbol(symbol), .rotor_sel(rotor_sel),
		.index_a(index_a), .index_b(index_b),
		.done(done), .out_symbol(out_symbol), .status(status),
		.mismatches(mismatches), .outstanding(outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("[rotor_cipher_engine_top] ERROR");
			$finish;
		end
	end

	function automatic int live_symbols();
		return (alpha_now > NSYM) ? NSYM : alpha_now;
	endfunction

	function automatic int live_rotors();
		return (rotors_now > NROT) ? NROT : rotors_now;
	endfunction

	// lowest keyboard slot in use that was never loaded, -1 when all are
	function automatic int first_blank();
		int i;
		first_blank = -1;
		for (i = live_symbols() - 1; i >= 0; i--)
			if (!kbd_set[i])
				first_blank = i;
	endfunction

	task automatic fresh_perm(input int n);
		int i;
		int j;
		int tmp;
		for (i = 0; i < n; i++)
			perm_buf[i] = i;
		for (i = n - 1; i > 0; i--) begin
			j = $urandom_range(0, i);
			tmp = perm_buf[i];
			perm_buf[i] = perm_buf[j];
			perm_buf[j] = tmp;
		end
	endtask

	task automatic send(input logic [2:0] f, input logic [7:0] s, input logic [2:0] r,
			input logic [5:0] a, input logic [5:0] b);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 3);
			if (gap > 0) begin
				start <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 80)
				: $urandom_range(1, 12);
		end
		burst_left--;
		start <= 1'b1;
		func <= f;
		symbol <= s;
		rotor_sel <= r;
		index_a <= a;
		index_b <= b;
		do @(posedge clk); while (busy);
		if (f == FN_LOAD_KBD) begin
			kbd_set[a] = 1'b1;
			kbd_copy[a] = s;
		end
	endtask

	// hold off until every result is back and the engine is idle
	task automatic drain();
		start <= 1'b0;
		do @(posedge clk); while (outstanding != 0 || busy);
	endtask

	task automatic cfg_write(input logic reg_idx, input int value);
		logic [31:0] noise;
		logic [31:0] val32;
		noise = $urandom;
		val32 = value;
		if (reg_idx == REG_ALPHABET_SIZE)
			alpha_now = value & 'h7F;
		else
			rotors_now = value & 'hF;
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {reg_idx, 2'b00};
		pwdata <= (reg_idx == REG_ALPHABET_SIZE) ? {noise[31:7], val32[6:0]}
			: {noise[31:4], val32[3:0]};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	// keyboard, one permutation per rotor and an involutive reflector, with a little noise
	task automatic load_cipher();
		int n;
		int nr;
		int i;
		int j;
		int tmp;
		int r;
		int roll;
		int pool [256];
		int mate [NSYM];
		logic [5:0] b;
		n = live_symbols();
		nr = live_rotors();
		for (i = 0; i < 256; i++)
			pool[i] = i;
		for (i = 255; i > 0; i--) begin
			j = $urandom_range(0, i);
			tmp = pool[i];
			pool[i] = pool[j];
			pool[j] = tmp;
		end
		for (i = 0; i < n; i++) begin
			if (i > 0 && $urandom_range(0, 15) == 0)
				send(FN_LOAD_KBD, kbd_copy[$urandom_range(0, i - 1)], 3'($urandom_range(0, 7)),
					6'(i), 6'($urandom_range(0, 63)));
			else
				send(FN_LOAD_KBD, 8'(pool[i]), 3'($urandom_range(0, 7)), 6'(i),
					6'($urandom_range(0, 63)));
		end
		for (r = 0; r < nr; r++) begin
			fresh_perm(n);
			for (i = 0; i < n; i++) begin
				roll = $urandom_range(0, 47);
				b = (roll == 1) ? 6'($urandom_range(0, 63)) : 6'(perm_buf[i]);
				if (roll != 0)
					send(FN_LOAD_ROT, 8'($urandom_range(0, 255)), 3'(r), 6'(i), b);
			end
		end
		fresh_perm(n);
		for (i = 0; i + 1 < n; i += 2) begin
			mate[perm_buf[i]] = perm_buf[i + 1];
			mate[perm_buf[i + 1]] = perm_buf[i];
		end
		if (n % 2 == 1)
			mate[perm_buf[n - 1]] = perm_buf[n - 1];
		for (i = 0; i < n; i++) begin
			roll = $urandom_range(0, 47);
			b = (roll == 1) ? 6'($urandom_range(0, 63)) : 6'(mate[i]);
			if (roll != 0)
				send(FN_LOAD_REFL, 8'($urandom_range(0, 255)), 3'($urandom_range(0, 7)),
					6'(i), b);
		end
	endtask

	task automatic random_item();
		int n;
		int nr;
		int roll;
		int blank;
		logic [2:0] f;
		logic [7:0] s;
		logic [2:0] r;
		logic [5:0] a;
		logic [5:0] b;
		n = live_symbols();
		nr = live_rotors();
		roll = $urandom_range(0, 99);
		s = 8'($urandom_range(0, 255));
		r = 3'($urandom_range(0, 7));
		a = 6'($urandom_range(0, 63));
		b = 6'($urandom_range(0, 63));
		if ($urandom_range(0, 39) == 0)
			drain();
		if (roll < 66) begin
			f = FN_ENCRYPT;
			if (n > 0 && $urandom_range(0, 9) != 0)
				s = kbd_copy[$urandom_range(0, n - 1)];
		end else if (roll < 76) begin
			f = FN_SET_POS;
			if (n > 0 && $urandom_range(0, 3) != 0)
				a = 6'($urandom_range(0, n - 1));
			if (nr > 0 && $urandom_range(0, 3) != 0)
				r = 3'($urandom_range(0, nr - 1));
		end else if (roll < 80) begin
			f = FN_RESET_POS;
		end else if (roll < 91) begin
			f = (roll < 86) ? FN_LOAD_ROT : FN_LOAD_REFL;
			if (n > 0 && $urandom_range(0, 2) != 0) begin
				a = 6'($urandom_range(0, n - 1));
				b = 6'($urandom_range(0, n - 1));
			end
		end else if (roll < 96) begin
			f = FN_LOAD_KBD;
		end else begin
			f = $urandom_range(0, 1) ? FN_SPARE_HI : FN_SPARE_LO;
		end
		// never let an encrypt search a keyboard slot that was never loaded
		blank = first_blank();
		if (f == FN_ENCRYPT && blank >= 0) begin
			f = FN_LOAD_KBD;
			a = 6'(blank);
		end
		send(f, s, r, a, b);
	endtask

	task automatic run_phase(input int alpha, input int rotors, input bit reload, input int cnt);
		drain();
		cfg_write(REG_ALPHABET_SIZE, alpha);
		cfg_write(REG_ROTOR_COUNT, rotors);
		if (reload)
			load_cipher();
		repeat (cnt) random_item();
	endtask

	task automatic directed_items();
		// empty keyboard: nothing can match
		send(FN_ENCRYPT, 8'h41, 3'd0, 6'd0, 6'd0);
		drain();
		cfg_write(REG_ALPHABET_SIZE, 4);
		cfg_write(REG_ROTOR_COUNT, 1);
		send(FN_LOAD_KBD, 8'h00, 3'd7, 6'd0, 6'd63);
		send(FN_LOAD_KBD, 8'hFF, 3'd0, 6'd1, 6'd0);
		send(FN_LOAD_KBD, 8'h5A, 3'd0, 6'd2, 6'd0);
		// repeated symbol, slot 1 must win
		send(FN_LOAD_KBD, 8'hFF, 3'd0, 6'd3, 6'd0);
		send(FN_LOAD_KBD, 8'hA5, 3'd0, 6'd63, 6'd0);
		send(FN_ENCRYPT, 8'h5A, 3'd0, 6'd0, 6'd0);
		send(FN_ENCRYPT, 8'h33, 3'd0, 6'd0, 6'd0);
		send(FN_LOAD_ROT, 8'h00, 3'd0, 6'd0, 6'd1);
		send(FN_LOAD_ROT, 8'h00, 3'd0, 6'd1, 6'd2);
		send(FN_LOAD_ROT, 8'h00, 3'd0, 6'd2, 6'd3);
		send(FN_LOAD_ROT, 8'h00, 3'd0, 6'd3, 6'd0);
		send(FN_LOAD_ROT, 8'hFF, 3'd7, 6'd63, 6'd63);
		// reflector still empty
		send(FN_ENCRYPT, 8'hFF, 3'd0, 6'd0, 6'd0);
		send(FN_LOAD_REFL, 8'h00, 3'd0, 6'd0, 6'd3);
		send(FN_LOAD_REFL, 8'h00, 3'd0, 6'd1, 6'd2);
		send(FN_LOAD_REFL, 8'h00, 3'd0, 6'd2, 6'd1);
		send(FN_LOAD_REFL, 8'h00, 3'd0, 6'd3, 6'd63);
		send(FN_LOAD_REFL, 8'h00, 3'd0, 6'd63, 6'd0);
		send(FN_ENCRYPT, 8'h00, 3'd0, 6'd0, 6'd0);
		send(FN_ENCRYPT, 8'h00, 3'd0, 6'd0, 6'd0);
		send(FN_SET_POS, 8'h00, 3'd0, 6'd3, 6'd0);
		// rotor at n-1 wraps to zero after this one
		send(FN_ENCRYPT, 8'h5A, 3'd0, 6'd0, 6'd0);
		// reflector sends index 63 back into the chain
		send(FN_ENCRYPT, 8'h5A, 3'd0, 6'd0, 6'd0);
		send(FN_SET_POS, 8'h00, 3'd1, 6'd0, 6'd0);
		send(FN_SET_POS, 8'h00, 3'd0, 6'd4, 6'd0);
		send(FN_SPARE_LO, 8'hC3, 3'd5, 6'd42, 6'd21);
		send(FN_SPARE_HI, 8'h3C, 3'd2, 6'd21, 6'd42);
		send(FN_RESET_POS, 8'h00, 3'd0, 6'd0, 6'd0);
		send(FN_ENCRYPT, 8'hFF, 3'd0, 6'd0, 6'd0);
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		// table clearing pass is running; the registers still take writes
		cfg_write(REG_ALPHABET_SIZE, 0);
		cfg_write(REG_ROTOR_COUNT, 0);
		directed_items();
		run_phase(64, 1, 1'b1, 40);
		run_phase(10, 8, 1'b1, 50);
		// oversized settings, old tables and stale positions
		run_phase(127, 1, 1'b0, 40);
		run_phase(1, 15, 1'b1, 40);
		run_phase(26, 3, 1'b1, 60);
		run_phase(5, 0, 1'b1, 40);
		drain();
		repeat (40) @(posedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("[rotor_cipher_engine_top] OK");
		else
			$display("[rotor_cipher_engine_top] ERROR");
		$finish;
	end

endmodule
